FILE: hdl/fpa_pkg.sv
// Package for the Q24.8 fixed-point ALU: opcodes, widths and defaults.
package fpa_pkg;

    localparam int unsigned DataWidth        = 32;
    localparam int unsigned OpWidth          = 4;
    localparam int unsigned FractionBitsDflt = 8;

    typedef enum logic [OpWidth-1:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_GT      = 4'd4,
        OP_LT      = 4'd5,
        OP_GE      = 4'd6,
        OP_LE      = 4'd7,
        OP_EQ      = 4'd8,
        OP_NE      = 4'd9,
        OP_MIN     = 4'd10,
        OP_MAX     = 4'd11,
        OP_INC     = 4'd12,
        OP_DEC     = 4'd13,
        OP_TOINT   = 4'd14,
        OP_FROMINT = 4'd15
    } t_op;

endpackage

FILE: hdl/fixed_point_q24_8_alu.sv
// Q24.8 fixed-point ALU top level: operand stage, divider/multiplier pipeline, result stage.
// One beat is accepted every cycle (busy stays low). Every beat passes through the operand
// register, the stage-2 register, the pipelined divider and the result register; the divider
// resolves four quotient bits per stage. All operations take that same path so results
// keep their order. The receiver cannot stall: o_done marks a result for one cycle.
module fixed_point_q24_8_alu #(
    parameter int unsigned FRACTION_BITS = fpa_pkg::FractionBitsDflt
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_op,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic        o_done,
    output logic signed [31:0] o_result_raw,
    output logic        o_compare_true,
    output logic        o_divide_by_zero
);
    localparam int unsigned DivBits   = 32 + FRACTION_BITS;
    localparam int unsigned DivStep   = 4;
    localparam int unsigned DivStages = (DivBits + DivStep - 1) / DivStep;

    typedef struct packed {
        logic [31:0] res;
        logic        cmp;
        logic        dz;
        logic        is_div;
        logic        neg;
    } t_tag;

    assign busy = 1'b0;

    // Stage 1: register operands and the signed multiply.
    logic               r_v1;
    fpa_pkg::t_op       r_op1;
    logic signed [31:0] r_a1, r_b1;
    logic signed [63:0] r_prod1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start;
        end
        r_op1   <= fpa_pkg::t_op'(i_op);
        r_a1    <= i_operand_a;
        r_b1    <= i_operand_b;
        r_prod1 <= i_operand_a * i_operand_b;
    end

    // Stage 2 logic: simple ops, compare, and divider operands.
    t_tag               n_tag;
    logic [DivBits-1:0] n_dvd;
    logic [31:0]        n_dvs;
    logic               a_lt, a_gt;
    logic [63:0]        prod_adj;
    logic [31:0]        a_adj;

    always_comb begin
        a_lt     = r_a1 < r_b1;
        a_gt     = r_a1 > r_b1;
        // Bias negatives so the arithmetic shift truncates toward zero.
        prod_adj = r_prod1 + (r_prod1[63] ? 64'((64'd1 << FRACTION_BITS) - 1) : 64'd0);
        a_adj    = r_a1 + (r_a1[31] ? 32'((32'd1 << FRACTION_BITS) - 1) : 32'd0);
        n_tag        = '0;
        n_tag.neg    = r_a1[31] ^ r_b1[31];
        n_dvd        = {(r_a1[31] ? 32'(-r_a1) : 32'(r_a1)), FRACTION_BITS'(0)};
        n_dvs        = r_b1[31] ? 32'(-r_b1) : 32'(r_b1);
        unique case (r_op1)
            fpa_pkg::OP_ADD:     n_tag.res = r_a1 + r_b1;
            fpa_pkg::OP_SUB:     n_tag.res = r_a1 - r_b1;
            fpa_pkg::OP_MUL:     n_tag.res = 32'($signed(prod_adj) >>> FRACTION_BITS);
            fpa_pkg::OP_DIV: begin
                n_tag.dz     = (r_b1 == 32'sd0);
                n_tag.is_div = (r_b1 != 32'sd0);
            end
            fpa_pkg::OP_GT:      n_tag.cmp = a_gt;
            fpa_pkg::OP_LT:      n_tag.cmp = a_lt;
            fpa_pkg::OP_GE:      n_tag.cmp = !a_lt;
            fpa_pkg::OP_LE:      n_tag.cmp = !a_gt;
            fpa_pkg::OP_EQ:      n_tag.cmp = (r_a1 == r_b1);
            fpa_pkg::OP_NE:      n_tag.cmp = (r_a1 != r_b1);
            fpa_pkg::OP_MIN:     n_tag.res = a_lt ? r_a1 : r_b1;
            fpa_pkg::OP_MAX:     n_tag.res = a_gt ? r_a1 : r_b1;
            fpa_pkg::OP_INC:     n_tag.res = r_a1 + 32'd1;
            fpa_pkg::OP_DEC:     n_tag.res = r_a1 - 32'd1;
            fpa_pkg::OP_TOINT:   n_tag.res = 32'($signed(a_adj) >>> FRACTION_BITS);
            fpa_pkg::OP_FROMINT: n_tag.res = r_a1 << FRACTION_BITS;
            default:             n_tag.res = '0;
        endcase
    end

    logic               r_v2;
    t_tag               r_tag2;
    logic [DivBits-1:0] r_dvd2;
    logic [31:0]        r_dvs2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_tag2 <= n_tag;
        r_dvd2 <= n_dvd;
        r_dvs2 <= r_b1 == 32'sd0 ? 32'd1 : n_dvs;
    end

    logic               div_v;
    logic [DivBits-1:0] div_q;
    t_tag               div_tag;

    fpa_div #(
        .NumBits      (DivBits),
        .BitsPerStage (DivStep),
        .TagWidth     ($bits(t_tag))
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v2),
        .i_dividend (r_dvd2),
        .i_divisor  (r_dvs2),
        .i_tag      (r_tag2),
        .o_valid    (div_v),
        .o_quotient (div_q),
        .o_tag      (div_tag)
    );

    // Final stage: apply the quotient sign and register the result beat.
    logic        r_done;
    logic [31:0] r_res;
    logic        r_cmp, r_dz;
    logic [31:0] q32;

    assign q32 = div_q[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= div_v;
        end
        r_res <= div_tag.is_div ? (div_tag.neg ? 32'(-q32) : q32) : div_tag.res;
        r_cmp <= div_tag.cmp;
        r_dz  <= div_tag.dz;
    end

    assign o_done           = r_done;
    assign o_result_raw     = r_res;
    assign o_compare_true   = r_cmp;
    assign o_divide_by_zero = r_dz;

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_divide_by_zero |-> o_result_raw == 32'd0 && !o_compare_true)
        else $error("divide by zero with nonzero result");
    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_compare_true |-> o_result_raw == 32'd0 && !o_divide_by_zero)
        else $error("compare with nonzero result");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> ##(DivStages + 1) o_done)
        else $error("beat lost in divider");
    a_start_v1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> r_v1)
        else $error("accepted beat not captured");
endmodule

FILE: hdl/fpa_div.sv
// Pipelined restoring divider: magnitude quotient of NumBits-wide dividend by 32-bit divisor.
module fpa_div #(
    parameter int unsigned NumBits      = 40,
    parameter int unsigned BitsPerStage = 4,
    parameter int unsigned TagWidth     = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [NumBits-1:0]  i_dividend,
    input  logic [31:0]         i_divisor,
    input  logic [TagWidth-1:0] i_tag,
    output logic                o_valid,
    output logic [NumBits-1:0]  o_quotient,
    output logic [TagWidth-1:0] o_tag
);
    localparam int unsigned NumStages = (NumBits + BitsPerStage - 1) / BitsPerStage;
    localparam int unsigned PadBits   = NumStages * BitsPerStage;

    logic [NumStages:1]               r_valid;
    logic [NumStages:1][PadBits-1:0]  r_num;
    logic [NumStages:1][32:0]         r_rem;
    logic [NumStages:1][31:0]         r_den;
    logic [NumStages:1][TagWidth-1:0] r_tag;

    for (genvar s = 0; s < NumStages; s++) begin : g_stage
        logic                c_valid;
        logic [PadBits-1:0]  c_num;
        logic [32:0]         c_rem;
        logic [31:0]         c_den;
        logic [TagWidth-1:0] c_tag;
        logic [PadBits-1:0]  n_num;
        logic [32:0]         n_rem;

        if (s == 0) begin : g_head
            // First stage takes the beat straight from the ports.
            assign c_valid = i_valid;
            assign c_num   = PadBits'(i_dividend);
            assign c_rem   = '0;
            assign c_den   = i_divisor;
            assign c_tag   = i_tag;
        end else begin : g_link
            assign c_valid = r_valid[s];
            assign c_num   = r_num[s];
            assign c_rem   = r_rem[s];
            assign c_den   = r_den[s];
            assign c_tag   = r_tag[s];
        end

        always_comb begin
            logic [33:0] trial;
            n_num = c_num;
            n_rem = c_rem;
            for (int k = 0; k < BitsPerStage; k++) begin
                trial = {n_rem, n_num[PadBits-1]} - {2'b0, c_den};
                n_num = {n_num[PadBits-2:0], 1'b0};
                if (!trial[33]) begin
                    n_rem    = trial[32:0];
                    n_num[0] = 1'b1;
                end else begin
                    n_rem = {n_rem[31:0], c_num[PadBits-1-k]};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s+1] <= 1'b0;
            end else begin
                r_valid[s+1] <= c_valid;
            end
            r_num[s+1] <= n_num;
            r_rem[s+1] <= n_rem;
            r_den[s+1] <= c_den;
            r_tag[s+1] <= c_tag;
        end
    end

    assign o_valid    = r_valid[NumStages];
    assign o_quotient = r_num[NumStages][NumBits-1:0];
    assign o_tag      = r_tag[NumStages];
endmodule
